// ----- sv/teed_pkg.sv -----
// ----------------------------------------------------------------------------
// teed_pkg
// Types and constants of the trace enter/exit detector.
// ----------------------------------------------------------------------------
package teed_pkg;

    localparam int DATA_W = 32;
    localparam int TOL_W  = 31;
    localparam int EXIT_W = 10;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_time;
        logic signed [DATA_W-1:0] sample_velocity;
        logic signed [DATA_W-1:0] sample_position;
        logic                     last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_position;
        logic signed [DATA_W-1:0] enter_time;
        logic signed [DATA_W-1:0] exit_time;
        logic        [EXIT_W-1:0] exit_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// ----- sv/trace_enter_exit_detector_core.sv -----
// ----------------------------------------------------------------------------
// trace_enter_exit_detector_core
// Finds the enter and exit times of one velocity trace.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in) takes one sample per
//   transaction; last_sample closes the trace. After a non-final sample the
//   block stays ready, and the next sample may follow in the next cycle.
//   On the final sample the block drops o_in_ready and scans the stored
//   samples backward from the next-to-last down to index 1 with one shared
//   compare unit: a RAM read (S_READ) and a compare (S_CHECK) per entry,
//   then S_DONE loads the output register. The scan stops at the first
//   departure it finds.
//   Output channel (o_out_valid/i_out_ready/o_out) carries one result per
//   trace from an output register; a stalled receiver holds it, and only a
//   second result waiting on it holds the block back.
//   Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes the
//   tolerance; it is always ready.
//   Reset clears the sequencer, the sample count and the output valid and
//   sets the tolerance to 655. The sample RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module trace_enter_exit_detector_core
    import teed_pkg::*;
#(
    parameter int MAX_STEPS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TOL_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out
);

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_STEPS - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

    t_state r_state, n_state;
    logic [TOL_W-1:0] r_tol;
    logic [IDX_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_scan_k, n_scan_k;
    logic r_enter_found, n_enter_found;
    logic r_out_valid, n_out_valid;

    logic signed [DATA_W-1:0] r_first_vel, n_first_vel;
    logic signed [DATA_W-1:0] r_first_time, n_first_time;
    logic signed [DATA_W-1:0] r_position, n_position;
    logic signed [DATA_W-1:0] r_enter_time, n_enter_time;
    logic signed [DATA_W-1:0] r_ref_vel, n_ref_vel;
    logic signed [DATA_W-1:0] r_exit_time, n_exit_time;
    logic [IDX_W-1:0] r_exit_idx, n_exit_idx;
    t_out_item r_out, n_out;

    logic in_acc;
    logic departs;
    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic [2*DATA_W-1:0] ram_wdata, ram_rdata;
    logic signed [DATA_W-1:0] rd_time, rd_vel;
    logic [IDX_W+EXIT_W-1:0] exit_wide;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign ram_wdata = {i_in.sample_time, i_in.sample_velocity};
    assign rd_time   = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_vel    = ram_rdata[DATA_W-1:0];

    assign cmp_a = (r_state == S_CHECK) ? rd_vel : i_in.sample_velocity;
    assign cmp_b = (r_state == S_CHECK) ? r_ref_vel : r_first_vel;

    assign exit_wide = {{EXIT_W{1'b0}}, r_exit_idx};

    teed_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_STEPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_count),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_k),
        .o_rdata (ram_rdata)
    );

    teed_cmp u_cmp (
        .i_a       (cmp_a),
        .i_b       (cmp_b),
        .i_tol     (r_tol),
        .o_departs (departs)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_scan_k      = r_scan_k;
        n_enter_found = r_enter_found;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_first_vel   = r_first_vel;
        n_first_time  = r_first_time;
        n_position    = r_position;
        n_enter_time  = r_enter_time;
        n_ref_vel     = r_ref_vel;
        n_exit_time   = r_exit_time;
        n_exit_idx    = r_exit_idx;
        n_out         = r_out;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count == '0) begin
                        n_first_vel  = i_in.sample_velocity;
                        n_first_time = i_in.sample_time;
                        n_position   = i_in.sample_position;
                    end else if (!r_enter_found && departs) begin
                        n_enter_time  = i_in.sample_time;
                        n_enter_found = 1'b1;
                    end
                    if (i_in.last_sample) begin
                        n_ref_vel   = i_in.sample_velocity;
                        n_exit_time = i_in.sample_time;
                        n_exit_idx  = r_count;
                        n_count     = '0;
                        n_scan_k    = r_count - ONE_IDX;
                        n_state     = (r_count > ONE_IDX) ? S_READ : S_DONE;
                    end else if (r_count != LAST_IDX) begin
                        n_count = r_count + ONE_IDX;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (departs) begin
                    n_exit_time = rd_time;
                    n_exit_idx  = r_scan_k;
                    n_state     = S_DONE;
                end else if (r_scan_k == ONE_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_k = r_scan_k - ONE_IDX;
                    n_state  = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.start_position = r_position;
                    n_out.enter_time     = r_enter_found ? r_enter_time : r_first_time;
                    n_out.exit_time      = r_exit_time;
                    n_out.exit_index     = exit_wide[EXIT_W-1:0];
                    n_out_valid          = 1'b1;
                    n_enter_found        = 1'b0;
                    n_state              = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_tol         <= TOL_RESET;
            r_count       <= '0;
            r_scan_k      <= '0;
            r_enter_found <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_scan_k      <= n_scan_k;
            r_enter_found <= n_enter_found;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_vel  <= n_first_vel;
        r_first_time <= n_first_time;
        r_position   <= n_position;
        r_enter_time <= n_enter_time;
        r_ref_vel    <= n_ref_vel;
        r_exit_time  <= n_exit_time;
        r_exit_idx   <= n_exit_idx;
        r_out        <= n_out;
    end

endmodule

// ----- sv/teed_ram.sv -----
// ----------------------------------------------------------------------------
// teed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module teed_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/teed_cmp.sv -----
// ----------------------------------------------------------------------------
// teed_cmp
// Shared departure compare: |a - b| > tolerance, exact in 33 bits.
// ----------------------------------------------------------------------------
module teed_cmp
    import teed_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic        [TOL_W-1:0]  i_tol,
    output logic                     o_departs
);

    logic signed [DATA_W:0] diff;
    logic signed [DATA_W:0] tol_pos;
    logic signed [DATA_W:0] tol_neg;

    assign diff    = {i_a[DATA_W-1], i_a} - {i_b[DATA_W-1], i_b};
    assign tol_pos = $signed({2'b00, i_tol});
    assign tol_neg = -tol_pos;

    assign o_departs = (diff > tol_pos) || (diff < tol_neg);

endmodule

// ----- sv/teed_checker.sv -----
// ----------------------------------------------------------------------------
// teed_checker
// Port-level checks of the trace enter/exit detector, bound to the top level.
// ----------------------------------------------------------------------------
module teed_checker
    import teed_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.last_sample |=> !o_in_ready)
        else $error("input ready right after a final sample");

    a_ready_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in.last_sample |=> o_in_ready)
        else $error("input stalled after a non-final sample");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a finished trace");

endmodule

bind trace_enter_exit_detector_core teed_checker u_teed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ----- tb/sv/trace_enter_exit_detector_core_test.sv -----
// ----------------------------------------------------------------------------
// trace_enter_exit_detector_core_test
// Self-checking bench for the trace enter/exit detector. A short table of
// hand-made traces (extremes, single-sample traces, tolerance edges) runs
// first, then random traces under several tolerances, one of them longer
// than the sample store. A shadow tracker predicts each trace summary, and
// every output transaction is checked field by field, in order.
// ----------------------------------------------------------------------------
module trace_enter_exit_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import teed_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HOLD_CYCLES = 500;
    localparam int IDLE_PAUSE  = 16;
    localparam int TAIL_CYCLES = 50;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 45;
    localparam int LONG_TRACE  = 1030;

    typedef struct packed {
        t_in_item  sample;
        logic      known;
        t_out_item want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [TOL_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out;

    t_out_item awaited_summaries[$];
    t_row      directed_rows[$];

    logic [TOL_W-1:0]         shadow_tol;
    logic signed [DATA_W-1:0] shadow_vel[DEPTH];
    logic signed [DATA_W-1:0] shadow_time[DEPTH];
    logic signed [DATA_W-1:0] shadow_v0;
    logic signed [DATA_W-1:0] shadow_pos0;
    logic signed [DATA_W-1:0] shadow_enter_t;
    bit                       shadow_entered;
    int unsigned              shadow_count;

    int mismatches;
    int cycle_count;
    bit tx_burst;
    bit rx_burst;
    bit hold_request;

    trace_enter_exit_detector_core #(
        .MAX_STEPS (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit departs(input logic signed [DATA_W-1:0] v,
                                   input logic signed [DATA_W-1:0] r);
        logic signed [DATA_W+1:0] d;
        d = {{2{v[DATA_W-1]}}, v} - {{2{r[DATA_W-1]}}, r};
        if (d < 0) begin
            d = -d;
        end
        return $unsigned(d) > {3'b000, shadow_tol};
    endfunction

    function automatic bit track_sample(input t_in_item s, output t_out_item res);
        int unsigned              idx;
        int unsigned              j;
        int unsigned              ex_i;
        logic signed [DATA_W-1:0] ex_t;
        bit                       hit;
        res = '0;
        idx = (shadow_count >= DEPTH) ? DEPTH - 1 : shadow_count;
        if (idx == 0) begin
            shadow_v0   = s.sample_velocity;
            shadow_pos0 = s.sample_position;
        end else if (!shadow_entered && departs(s.sample_velocity, shadow_v0)) begin
            shadow_enter_t = s.sample_time;
            shadow_entered = 1'b1;
        end
        shadow_vel[idx]  = s.sample_velocity;
        shadow_time[idx] = s.sample_time;
        if (!s.last_sample) begin
            shadow_count = (idx < DEPTH - 1) ? idx + 1 : idx;
            return 1'b0;
        end
        ex_t = s.sample_time;
        ex_i = idx;
        hit  = 1'b0;
        for (j = idx; j >= 2 && !hit; j--) begin
            if (departs(shadow_vel[j-1], s.sample_velocity)) begin
                ex_t = shadow_time[j-1];
                ex_i = j - 1;
                hit  = 1'b1;
            end
        end
        res.start_position = shadow_pos0;
        res.enter_time     = shadow_entered ? shadow_enter_t : shadow_time[0];
        res.exit_time      = ex_t;
        res.exit_index     = EXIT_W'(ex_i);
        shadow_count   = 0;
        shadow_entered = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] near(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] tol32;
        tol32 = {1'b0, shadow_tol};
        case ($urandom_range(0, 5))
            0: begin
                return x + tol32;
            end
            1: begin
                return x + tol32 + 1;
            end
            2: begin
                return x - tol32;
            end
            3: begin
                return x - tol32 - 1;
            end
            4: begin
                return x + ($urandom % (tol32 + 1)) - (tol32 >> 1);
            end
            default: begin
                return x;
            end
        endcase
    endfunction

    task automatic send_sample(input t_in_item s, input bit known, input t_out_item want);
        int        gap;
        t_out_item res;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= s;
        do @(posedge i_clk); while (!o_in_ready);
        if (track_sample(s, res)) begin
            awaited_summaries.push_back(known ? want : res);
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (awaited_summaries.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        release_input();
        drain();
        repeat (IDLE_PAUSE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_tol = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_trace(input int len, input int calm);
        logic [DATA_W-1:0] v_first;
        logic [DATA_W-1:0] v_last;
        logic [DATA_W-1:0] t0;
        logic [DATA_W-1:0] step;
        t_in_item          s;
        int                r;
        tx_burst = ($urandom_range(0, 3) == 0);
        v_first  = $urandom;
        r        = $urandom_range(0, 9);
        v_last   = (r < 4) ? v_first : (r < 7) ? near(v_first) : $urandom;
        t0       = $urandom;
        step     = $urandom_range(1, 32'h0002_0000);
        for (int i = 0; i < len; i++) begin
            s.sample_time     = t0 + i * step;
            s.sample_position = $urandom;
            s.last_sample     = (i == len - 1);
            if (i == 0) begin
                s.sample_velocity = v_first;
            end else if (i == len - 1) begin
                s.sample_velocity = v_last;
            end else if ($urandom_range(0, 99) < calm) begin
                s.sample_velocity = v_last;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    s.sample_velocity = near(v_last);
                end else if (r < 65) begin
                    s.sample_velocity = near(v_first);
                end else if (r < 75) begin
                    s.sample_velocity = v_last;
                end else if (r < 85) begin
                    s.sample_velocity = v_first;
                end else begin
                    s.sample_velocity = $urandom;
                end
            end
            send_sample(s, 1'b0, '0);
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 1;
        end
        if (r < 35) begin
            return 2;
        end
        if (r < 80) begin
            return $urandom_range(3, 10);
        end
        if (r < 97) begin
            return $urandom_range(11, 40);
        end
        return $urandom_range(41, 120);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_summaries.size() == 0) begin
                $error("summary transaction with no trace pending");
                mismatches++;
            end else begin
                want = awaited_summaries.pop_front();
                if (o_out.start_position !== want.start_position) begin
                    $error("start_position: expected %0d, got %0d",
                           want.start_position, o_out.start_position);
                    mismatches++;
                end
                if (o_out.enter_time !== want.enter_time) begin
                    $error("enter_time: expected %0d, got %0d",
                           want.enter_time, o_out.enter_time);
                    mismatches++;
                end
                if (o_out.exit_time !== want.exit_time) begin
                    $error("exit_time: expected %0d, got %0d",
                           want.exit_time, o_out.exit_time);
                    mismatches++;
                end
                if (o_out.exit_index !== want.exit_index) begin
                    $error("exit_index: expected %0d, got %0d",
                           want.exit_index, o_out.exit_index);
                    mismatches++;
                end
            end
        end
    end

    initial begin : receiver
        int r;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if ($urandom_range(0, 299) == 0) begin
                    rx_burst = !rx_burst;
                end
                r = $urandom_range(0, 99);
                if (rx_burst || r < 65) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    if (r >= 95) begin
                        repeat ($urandom_range(10, 60)) @(negedge i_clk);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [TOL_W-1:0] tol_plan[6];
        int               sent;
        int               len;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        shadow_tol     = TOL_RESET;
        shadow_v0      = '0;
        shadow_pos0    = '0;
        shadow_enter_t = '0;
        shadow_entered = 1'b0;
        shadow_count   = 0;

        // single-sample traces, extremes, two-sample trace, flat trace
        directed_rows.push_back('{t_in_item'{32'h0001_0000, 32'h0000_1234, 32'h0002_0000, 1'b1},
            1'b1, t_out_item'{32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 10'd0}});
        directed_rows.push_back('{t_in_item'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
            1'b1, t_out_item'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'd0}});
        directed_rows.push_back('{t_in_item'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
            1'b1, t_out_item'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0}});
        directed_rows.push_back('{t_in_item'{32'd10, 32'h8000_0000, 32'd5, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd20, 32'h7FFF_FFFF, 32'd9, 1'b1},
            1'b1, t_out_item'{32'd5, 32'd20, 32'd20, 10'd1}});
        directed_rows.push_back('{t_in_item'{32'd1, 32'd100, 32'hFFFF_FFF9, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd2, 32'd100, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd3, 32'd100, 32'd0, 1'b1},
            1'b1, t_out_item'{32'hFFFF_FFF9, 32'd1, 32'd3, 10'd2}});
        // tolerance edges on both sides of the first and final velocity
        directed_rows.push_back('{t_in_item'{32'd100, 32'd0, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd101, 32'd655, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd102, 32'd656, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd103, -32'sd656, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd104, 32'd0, 32'd0, 1'b1}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd200, 32'h0001_0000, 32'h1234, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd201, 32'h0000_FD71, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd202, 32'h0000_FD70, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd203, 32'h0001_0000, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd204, 32'h0001_0000, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'd205, 32'h0001_028F, 32'd0, 1'b1}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'hFFFF_FED4, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0},
            1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'hFFFF_FED5, 32'h8000_0000, 32'd0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{t_in_item'{32'hFFFF_FED6, 32'h7FFF_FFFF, 32'd0, 1'b1}, 1'b0, '0});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            tx_burst = 1'b0;
            send_sample(directed_rows[k].sample, directed_rows[k].known, directed_rows[k].want);
        end

        tol_plan = '{TOL_W'(0), TOL_W'(32'h7FFF_FFFF), TOL_W'($urandom),
                     TOL_W'($urandom_range(1, 4096)), TOL_W'(1), TOL_RESET};
        for (int ph = 0; ph < 6; ph++) begin
            set_tolerance(tol_plan[ph]);
            if (ph == 1) begin
                hold_request = 1'b1;
            end
            if (ph == 3) begin
                run_trace(LONG_TRACE, 97);
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = pick_length();
                run_trace(len, 15);
                sent += len;
            end
        end

        release_input();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/teed_pkg.sv
sv/teed_ram.sv
sv/teed_cmp.sv
sv/trace_enter_exit_detector_core.sv
sv/teed_checker.sv
tb/sv/trace_enter_exit_detector_core_test.sv
